// ----- rtl/assert_macros.svh -----
// assertion macros used by the queue unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property checked while out of reset
`define KDRQ_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// property checked on every edge
`define KDRQ_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define KDRQ_ASSERT(name, prop, msg)
`define KDRQ_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

// ----- rtl/kdrq_pkg.sv -----
package kdrq_pkg;
    localparam int QUEUE_DEPTH = 16;
    localparam int ENTRY_COUNT = 256;
    localparam int KEY_BITS    = 32;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 8;
    localparam int MARK_W      = $clog2(ENTRY_COUNT);

    localparam logic [2:0] ACT_INS_TAIL = 3'd0;
    localparam logic [2:0] ACT_INS_KEY  = 3'd1;
    localparam logic [2:0] ACT_RM_HEAD  = 3'd2;
    localparam logic [2:0] ACT_RM_KEY   = 3'd3;
    localparam logic [2:0] ACT_RM_ENTRY = 3'd4;

    localparam logic [1:0] STS_OK   = 2'd0;
    localparam logic [1:0] STS_FULL = 2'd1;
    localparam logic [1:0] STS_DUP  = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [KEY_BITS-1:0] key;
    } entry_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        entry_t            wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;
endpackage

// ----- rtl/kdrq_ram.sv -----
module kdrq_ram (
    input  logic               aclk,
    input  kdrq_pkg::mem_req_t req,
    output kdrq_pkg::entry_t   rdata
);
    kdrq_pkg::entry_t mem [kdrq_pkg::QUEUE_DEPTH];
    kdrq_pkg::entry_t rdata_reg;

    // one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- rtl/keyed_device_request_queue_unit.sv -----
// channel | direction | tdata (low bit up)                     | tuser
// s_      | in        | entry_id[7:0], sort_key[39:8]          | action[2:0]
// m_      | out       | was_queued, removed_valid, removed_id, |
//         |           | busy_now, status, zero pad             |
// a request with no queue walk goes through accept, mark lookup and result;
// a search visits each entry in a read and a check state, and each shifted entry
// moves in a read and a write state, all through the single read and write port
// of the queue memory; aresetn clears busy and count, then a pass over all 256
// ids clears the queued marks with s_tready low; queue memory is not cleared
// a new beat is accepted while the previous result still waits on m_tready;
// the next result then holds until that beat leaves
module keyed_device_request_queue_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // entry_id, sort_key
    input  logic [2:0]  s_tuser,  // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // was_queued, removed_valid, removed_id, busy_now, status
);
    `include "assert_macros.svh"

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SRCH_RD = 4'd1;
    localparam logic [3:0] S_SRCH_CK = 4'd2;
    localparam logic [3:0] S_TAKE_RD = 4'd3;
    localparam logic [3:0] S_TAKE_CK = 4'd4;
    localparam logic [3:0] S_DN_RD   = 4'd5;
    localparam logic [3:0] S_DN_WR   = 4'd6;
    localparam logic [3:0] S_UP_RD   = 4'd7;
    localparam logic [3:0] S_UP_WR   = 4'd8;
    localparam logic [3:0] S_FIN     = 4'd9;
    localparam logic [3:0] S_CLR     = 4'd10;
    localparam logic [3:0] S_DECIDE  = 4'd11;

    logic [3:0]                    st_reg, st_next;
    logic [2:0]                    act_reg, act_next;
    logic [kdrq_pkg::ID_W-1:0]     id_reg, id_next;
    logic [kdrq_pkg::KEY_BITS-1:0] key_reg, key_next;
    logic [kdrq_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [kdrq_pkg::CNT_W-1:0]    ptr_reg, ptr_next;
    logic [kdrq_pkg::CNT_W-1:0]    pos_reg, pos_next;
    logic                          busy_reg, busy_next;
    logic [kdrq_pkg::MARK_W-1:0]   clr_reg, clr_next;
    logic                          wq_reg, wq_next;
    logic                          rv_reg, rv_next;
    logic [kdrq_pkg::ID_W-1:0]     rid_reg, rid_next;
    logic [1:0]                    sts_reg, sts_next;
    logic                          mv_reg, mv_next;
    logic [15:0]                   mdata_reg, mdata_next;

    logic                          marks_mem [kdrq_pkg::ENTRY_COUNT];
    logic                          mark_rd_reg;
    logic                          mark_we;
    logic [kdrq_pkg::MARK_W-1:0]   mark_waddr;
    logic                          mark_wdata;
    logic [kdrq_pkg::MARK_W-1:0]   mark_raddr;

    kdrq_pkg::mem_req_t req;
    kdrq_pkg::entry_t   rdata;
    logic               hit;
    logic [2:0]         in_act;
    logic [kdrq_pkg::ID_W-1:0] in_id;

    kdrq_ram u_ram (
        .aclk  (aclk),
        .req   (req),
        .rdata (rdata)
    );

    assign in_act   = s_tuser;
    assign in_id    = s_tdata[7:0];
    assign s_tready = (st_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;

    // queued marks, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mark_we) begin
            marks_mem[mark_waddr] <= mark_wdata;
        end
        mark_rd_reg <= marks_mem[mark_raddr];
    end

    // match test for the entry just read during a search
    always_comb begin
        unique case (act_reg)
            kdrq_pkg::ACT_INS_KEY:  hit = (key_reg < rdata.key);
            kdrq_pkg::ACT_RM_KEY:   hit = !(key_reg > rdata.key);
            default:                hit = (rdata.id == id_reg);
        endcase
    end

    // request sequencer
    always_comb begin
        st_next    = st_reg;
        act_next   = act_reg;
        id_next    = id_reg;
        key_next   = key_reg;
        cnt_next   = cnt_reg;
        ptr_next   = ptr_reg;
        pos_next   = pos_reg;
        busy_next  = busy_reg;
        clr_next   = clr_reg;
        wq_next    = wq_reg;
        rv_next    = rv_reg;
        rid_next   = rid_reg;
        sts_next   = sts_reg;
        mv_next    = mv_reg;
        mdata_next = mdata_reg;
        req.we     = 1'b0;
        req.waddr  = ptr_reg[kdrq_pkg::ADDR_W-1:0];
        req.wdata  = rdata;
        req.raddr  = ptr_reg[kdrq_pkg::ADDR_W-1:0];
        mark_we    = 1'b0;
        mark_waddr = id_reg;
        mark_wdata = 1'b0;
        mark_raddr = in_id;

        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end

        unique case (st_reg)
            // clear the queued marks after reset
            S_CLR: begin
                mark_we    = 1'b1;
                mark_waddr = clr_reg;
                if (clr_reg == '1) begin
                    st_next = S_IDLE;
                end else begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    act_next = in_act;
                    id_next  = in_id;
                    key_next = s_tdata[39:8];
                    wq_next  = 1'b0;
                    rv_next  = 1'b0;
                    rid_next = '0;
                    sts_next = kdrq_pkg::STS_OK;
                    ptr_next = '0;
                    pos_next = '0;
                    st_next  = S_DECIDE;
                end
            end
            // mark of the requested id is now available
            S_DECIDE: begin
                st_next = S_FIN;
                unique case (act_reg)
                    kdrq_pkg::ACT_INS_TAIL, kdrq_pkg::ACT_INS_KEY: begin
                        priority if (mark_rd_reg) begin
                            sts_next = kdrq_pkg::STS_DUP;
                            wq_next  = 1'b1;
                        end else if (!busy_reg) begin
                            busy_next = 1'b1;
                        end else if (cnt_reg == kdrq_pkg::CNT_W'(kdrq_pkg::QUEUE_DEPTH)) begin
                            sts_next = kdrq_pkg::STS_FULL;
                        end else if (act_reg == kdrq_pkg::ACT_INS_TAIL) begin
                            pos_next = cnt_reg;
                            ptr_next = cnt_reg;
                            st_next  = S_UP_RD;
                        end else begin
                            st_next = S_SRCH_RD;
                        end
                    end
                    kdrq_pkg::ACT_RM_HEAD, kdrq_pkg::ACT_RM_KEY: begin
                        priority if (cnt_reg == '0) begin
                            busy_next = 1'b0;
                        end else if (act_reg == kdrq_pkg::ACT_RM_HEAD) begin
                            st_next = S_TAKE_RD;
                        end else begin
                            st_next = S_SRCH_RD;
                        end
                    end
                    kdrq_pkg::ACT_RM_ENTRY: begin
                        if (mark_rd_reg) begin
                            st_next = S_SRCH_RD;
                        end
                    end
                    default: begin
                        st_next = S_FIN;
                    end
                endcase
            end
            // walk the queue one entry at a time, a read state then a check state
            S_SRCH_RD: begin
                if (ptr_reg == cnt_reg) begin
                    unique case (act_reg)
                        kdrq_pkg::ACT_INS_KEY: begin
                            pos_next = cnt_reg;
                            st_next  = S_UP_RD;
                        end
                        kdrq_pkg::ACT_RM_KEY: begin
                            pos_next = '0;
                            st_next  = S_TAKE_RD;
                        end
                        default: begin
                            mark_we = 1'b1;
                            st_next = S_FIN;
                        end
                    endcase
                end else begin
                    st_next = S_SRCH_CK;
                end
            end
            S_SRCH_CK: begin
                if (hit) begin
                    pos_next = ptr_reg;
                    if (act_reg == kdrq_pkg::ACT_INS_KEY) begin
                        ptr_next = cnt_reg;
                        st_next  = S_UP_RD;
                    end else begin
                        st_next = S_TAKE_RD;
                    end
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                    st_next  = S_SRCH_RD;
                end
            end
            // fetch the entry being removed
            S_TAKE_RD: begin
                req.raddr = pos_reg[kdrq_pkg::ADDR_W-1:0];
                st_next   = S_TAKE_CK;
            end
            S_TAKE_CK: begin
                rid_next = rdata.id;
                ptr_next = pos_reg;
                st_next  = S_DN_RD;
            end
            // close the gap toward the head
            S_DN_RD: begin
                req.raddr = ptr_next_addr(ptr_reg);
                if ((ptr_reg + 1'b1) >= cnt_reg) begin
                    cnt_next   = cnt_reg - 1'b1;
                    mark_we    = 1'b1;
                    mark_waddr = rid_reg;
                    rv_next    = 1'b1;
                    wq_next    = (act_reg == kdrq_pkg::ACT_RM_ENTRY);
                    st_next    = S_FIN;
                end else begin
                    st_next = S_DN_WR;
                end
            end
            S_DN_WR: begin
                req.we   = 1'b1;
                ptr_next = ptr_reg + 1'b1;
                st_next  = S_DN_RD;
            end
            // open a gap at the insert position
            S_UP_RD: begin
                req.raddr = ptr_prev_addr(ptr_reg);
                if (ptr_reg == pos_reg) begin
                    req.we        = 1'b1;
                    req.wdata.id  = id_reg;
                    req.wdata.key = key_reg;
                    cnt_next      = cnt_reg + 1'b1;
                    mark_we       = 1'b1;
                    mark_wdata    = 1'b1;
                    wq_next       = 1'b1;
                    st_next       = S_FIN;
                end else begin
                    st_next = S_UP_WR;
                end
            end
            S_UP_WR: begin
                req.we   = 1'b1;
                ptr_next = ptr_reg - 1'b1;
                st_next  = S_UP_RD;
            end
            // hand the result to the output register
            S_FIN: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    mdata_next = {3'b000, sts_reg, busy_reg, rid_reg, rv_reg, wq_reg};
                    st_next    = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    function automatic logic [kdrq_pkg::ADDR_W-1:0] ptr_next_addr(
        input logic [kdrq_pkg::CNT_W-1:0] p);
        logic [kdrq_pkg::CNT_W-1:0] n;
        n = p + 1'b1;
        return n[kdrq_pkg::ADDR_W-1:0];
    endfunction

    function automatic logic [kdrq_pkg::ADDR_W-1:0] ptr_prev_addr(
        input logic [kdrq_pkg::CNT_W-1:0] p);
        logic [kdrq_pkg::CNT_W-1:0] n;
        n = p - 1'b1;
        return n[kdrq_pkg::ADDR_W-1:0];
    endfunction

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= S_CLR;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            clr_reg  <= '0;
            mv_reg   <= 1'b0;
        end else begin
            st_reg   <= st_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            clr_reg  <= clr_next;
            mv_reg   <= mv_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        act_reg   <= act_next;
        id_reg    <= id_next;
        key_reg   <= key_next;
        ptr_reg   <= ptr_next;
        pos_reg   <= pos_next;
        wq_reg    <= wq_next;
        rv_reg    <= rv_next;
        rid_reg   <= rid_next;
        sts_reg   <= sts_next;
        mdata_reg <= mdata_next;
    end

    `KDRQ_ASSERT(a_cnt_max, cnt_reg <= kdrq_pkg::CNT_W'(kdrq_pkg::QUEUE_DEPTH), "count over depth")
    `KDRQ_ASSERT(a_accept_busy, (s_tvalid && s_tready) |=> (st_reg != S_IDLE), "beat dropped")
    `KDRQ_ASSERT(a_out_from_fin, $rose(mv_reg) |-> ($past(st_reg) == S_FIN), "stray result")
    `KDRQ_ASSERT(a_cnt_step, (cnt_reg == $past(cnt_reg)) || (cnt_reg == $past(cnt_reg) + 1'b1) || (cnt_reg == $past(cnt_reg) - 1'b1), "count jump")
endmodule
